// ===== design/icpm_pkg.sv =====
package icpm_pkg;

  // Operation carried by one input item.
  typedef enum logic [2:0] {
    CMD_READ      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_RAISE_EXT = 3'd2,
    CMD_RAISE_SRC = 3'd3,
    CMD_RAISE_SUB = 3'd4
  } cmd_t;

  // Register map of the bus side.
  typedef enum logic [3:0] {
    REG_SRCPND    = 4'd0,
    REG_MODE      = 4'd1,
    REG_MASK      = 4'd2,
    REG_PRIORITY  = 4'd3,
    REG_INTPND    = 4'd4,
    REG_INTOFFSET = 4'd5,
    REG_SUBSRCPND = 4'd6,
    REG_SUBMASK   = 4'd7,
    REG_EXTMASK   = 4'd8,
    REG_EXTPEND   = 4'd9
  } reg_t;

  localparam int SubWidth = 11;
  localparam int ExtWidth = 24;

  // Sub-source groups; the transmit bits of the three UARTs are always pending.
  localparam logic [SubWidth-1:0] SUB_TX_ALWAYS = 11'h092;
  localparam logic [SubWidth-1:0] SUB_GRP_UART0 = 11'h007;
  localparam logic [SubWidth-1:0] SUB_GRP_UART1 = 11'h038;
  localparam logic [SubWidth-1:0] SUB_GRP_UART2 = 11'h1C0;
  localparam logic [SubWidth-1:0] SUB_GRP_ADC   = 11'h600;

  // External line groups and the lines that a write may clear.
  localparam logic [ExtWidth-1:0] EXT_GRP_LOW   = 24'h0000F0;
  localparam logic [ExtWidth-1:0] EXT_GRP_HIGH  = 24'hFFFF00;
  localparam logic [ExtWidth-1:0] EXT_CLEARABLE = 24'hFFFFF0;
  localparam logic [31:0]         EXT_MASK_RESET = 32'h00FF_FFF0;

  // Main source bit positions fed by the fold.
  localparam int SRC_EXT_LOW  = 4;
  localparam int SRC_EXT_HIGH = 5;
  localparam int SRC_UART2    = 15;
  localparam int SRC_UART1    = 23;
  localparam int SRC_UART0    = 28;
  localparam int SRC_ADC      = 31;

  localparam logic [31:0] READ_UNMAPPED = 32'hFFFF_FFFF;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [4:0] lowest_index(input logic [31:0] value);
    logic [31:0] iso;
    logic [4:0]  idx;
    iso = value & (~value + 32'd1);
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (iso[i]) begin
        idx = idx | 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== design/interrupt_controller_pending_mask.sv =====
// Interrupt controller with source, sub-source and external pending words.
// Input channel (in_valid/in_stall) carries one item per operation: a bus
// read or write of one of ten registers, or the raising of an external line,
// a main source bit or a sub-source bit. Output channel (out_valid/out_stall)
// returns exactly one item per input item: read_data (zero unless a read)
// and the irq_request/fiq_request levels after that item's update.
// An accepted item sits in the operation register, is evaluated against the
// state in one pass and lands in the result register. One item per cycle is
// sustained while out_stall stays low; the single-pass update of the state
// registers sets that figure, as each item sees the previous one's state.
// A stalled result holds; the operation register keeps taking items until it
// is itself occupied, so in_stall rises only when both stages are full.
// Synchronous reset empties both stages and loads the register reset values
// (mask all ones, external mask 0x00FFFFF0, all else zero).
module interrupt_controller_pending_mask (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [3:0]  reg_sel,
  input  logic [31:0] write_data,
  input  logic [4:0]  line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        irq_request,
  output logic        fiq_request
);
  import icpm_pkg::*;

  // Operation register.
  logic        op_valid;
  cmd_t        op_cmd;
  reg_t        op_reg;
  logic [31:0] op_data;
  logic [4:0]  op_line;

  // Controller state.
  logic [31:0]         source_pending;
  logic [31:0]         mode_select;
  logic [31:0]         source_mask;
  logic [31:0]         priority_word;
  logic [31:0]         service_pending;
  logic [4:0]          service_offset;
  logic [SubWidth-1:0] sub_pending;
  logic [31:0]         sub_mask;
  logic [31:0]         ext_mask;
  logic [ExtWidth-1:0] ext_pending;

  logic [31:0]         source_pending_next;
  logic [31:0]         mode_select_next;
  logic [31:0]         source_mask_next;
  logic [31:0]         priority_word_next;
  logic [31:0]         service_pending_next;
  logic [4:0]          service_offset_next;
  logic [SubWidth-1:0] sub_pending_next;
  logic [31:0]         sub_mask_next;
  logic [31:0]         ext_mask_next;
  logic [ExtWidth-1:0] ext_pending_next;

  logic [31:0]         read_data_next;
  logic                irq_request_next;
  logic                fiq_request_next;
  logic [4:0]          scan_index;
  logic                scan_hit;
  logic [SubWidth-1:0] sub_request;
  logic [ExtWidth-1:0] ext_request;
  logic [31:0]         request;

  logic accept;
  logic advance;
  logic fire;

  // Handshake: the result register frees when empty or taken.
  assign advance  = !out_valid || !out_stall;
  assign fire     = op_valid && advance;
  assign in_stall = op_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Operation register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (accept) begin
      op_valid <= 1'b1;
    end else if (advance) begin
      op_valid <= 1'b0;
    end
    if (accept) begin
      op_cmd  <= cmd_t'(cmd);
      op_reg  <= reg_t'(reg_sel);
      op_data <= write_data;
      op_line <= line;
    end
  end

  // Single-pass evaluation of one item against the current state.
  always_comb begin
    source_pending_next  = source_pending;
    mode_select_next     = mode_select;
    source_mask_next     = source_mask;
    priority_word_next   = priority_word;
    service_pending_next = service_pending;
    service_offset_next  = service_offset;
    sub_pending_next     = sub_pending;
    sub_mask_next        = sub_mask;
    ext_mask_next        = ext_mask;
    ext_pending_next     = ext_pending;
    read_data_next       = '0;
    scan_index           = lowest_index(source_pending);
    scan_hit             = |source_pending;

    unique case (op_cmd)
      CMD_READ: begin
        unique case (op_reg) inside
          REG_SRCPND:    read_data_next = source_pending;
          REG_MODE:      read_data_next = mode_select;
          REG_MASK:      read_data_next = source_mask;
          REG_PRIORITY:  read_data_next = priority_word;
          REG_INTPND, REG_INTOFFSET: begin
            // The scan ignores the mask; an empty word keeps the old offset.
            if (scan_hit) begin
              service_offset_next = scan_index;
              read_data_next = (op_reg == REG_INTPND) ? (32'd1 << scan_index)
                                                       : 32'(scan_index);
            end
            service_pending_next = 32'd1 << service_offset_next;
          end
          REG_SUBSRCPND: read_data_next = 32'(sub_pending);
          REG_SUBMASK:   read_data_next = sub_mask;
          REG_EXTMASK:   read_data_next = ext_mask;
          REG_EXTPEND:   read_data_next = 32'(ext_pending);
          default:       read_data_next = READ_UNMAPPED;
        endcase
      end
      CMD_WRITE: begin
        unique case (op_reg)
          REG_SRCPND:    source_pending_next = source_pending & ~op_data;
          REG_MODE:      mode_select_next = op_data;
          REG_MASK:      source_mask_next = op_data;
          REG_PRIORITY:  priority_word_next = op_data;
          REG_INTPND: begin
            service_pending_next = service_pending & ~op_data;
            service_offset_next  = '0;
          end
          REG_SUBSRCPND: sub_pending_next = sub_pending & ~op_data[SubWidth-1:0];
          REG_SUBMASK:   sub_mask_next = op_data;
          REG_EXTMASK:   ext_mask_next = op_data;
          REG_EXTPEND: begin
            ext_pending_next = ext_pending & ~op_data[ExtWidth-1:0] & EXT_CLEARABLE;
          end
          default: ;
        endcase
      end
      CMD_RAISE_EXT: ext_pending_next = ext_pending | (ExtWidth'(1) << op_line);
      CMD_RAISE_SRC: source_pending_next = source_pending | (32'd1 << op_line);
      CMD_RAISE_SUB: sub_pending_next = sub_pending | (SubWidth'(1) << op_line);
      default: ;
    endcase

    // Fold unmasked sub-source and external bits into the source word.
    sub_pending_next = sub_pending_next | SUB_TX_ALWAYS;
    sub_request = sub_pending_next & ~sub_mask_next[SubWidth-1:0];
    ext_request = ext_pending_next & ~ext_mask_next[ExtWidth-1:0];
    if (|(sub_request & SUB_GRP_UART0)) source_pending_next[SRC_UART0] = 1'b1;
    if (|(sub_request & SUB_GRP_UART1)) source_pending_next[SRC_UART1] = 1'b1;
    if (|(sub_request & SUB_GRP_UART2)) source_pending_next[SRC_UART2] = 1'b1;
    if (|(sub_request & SUB_GRP_ADC))   source_pending_next[SRC_ADC]   = 1'b1;
    if (|(ext_request & EXT_GRP_LOW))   source_pending_next[SRC_EXT_LOW]  = 1'b1;
    if (|(ext_request & EXT_GRP_HIGH))  source_pending_next[SRC_EXT_HIGH] = 1'b1;

    // Request lines from the unmasked pending sources, split by mode.
    request          = source_pending_next & ~source_mask_next;
    irq_request_next = |(request & ~mode_select_next);
    fiq_request_next = |(request & mode_select_next);
  end

  // State update, once per evaluated item.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_pending  <= '0;
      mode_select     <= '0;
      source_mask     <= '1;
      priority_word   <= '0;
      service_pending <= '0;
      service_offset  <= '0;
      sub_pending     <= '0;
      sub_mask        <= '0;
      ext_mask        <= EXT_MASK_RESET;
      ext_pending     <= '0;
    end else if (fire) begin
      source_pending  <= source_pending_next;
      mode_select     <= mode_select_next;
      source_mask     <= source_mask_next;
      priority_word   <= priority_word_next;
      service_pending <= service_pending_next;
      service_offset  <= service_offset_next;
      sub_pending     <= sub_pending_next;
      sub_mask        <= sub_mask_next;
      ext_mask        <= ext_mask_next;
      ext_pending     <= ext_pending_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= op_valid;
    end
    if (fire) begin
      read_data   <= read_data_next;
      irq_request <= irq_request_next;
      fiq_request <= fiq_request_next;
    end
  end

`ifndef NO_ASSERTIONS
  // The entry stage only pushes back when it actually holds an item.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> op_valid)
    else $error("input stalled with an empty operation register");

  // Every evaluated item leaves the UART transmit sub-source bits set.
  assert property (@(posedge clk) disable iff (rst)
    fire |=> ((sub_pending & SUB_TX_ALWAYS) == SUB_TX_ALWAYS))
    else $error("transmit sub-source bits not pending after an item");

  // Items other than reads return zero data.
  assert property (@(posedge clk) disable iff (rst)
    (fire && op_cmd != CMD_READ) |=> (read_data == '0))
    else $error("nonzero read data for a non-read item");

  // The in-service word never holds more than one bit.
  assert property (@(posedge clk) disable iff (rst) $onehot0(service_pending))
    else $error("service pending word has several bits set");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;
  import icpm_pkg::*;

  // Codes past the end of the operation and register encodings.
  localparam logic [2:0] CMD_FIRST_UNKNOWN  = 3'd5;
  localparam logic [2:0] CMD_LAST_CODE      = 3'd7;
  localparam logic [3:0] REG_FIRST_UNMAPPED = 4'd10;
  localparam logic [3:0] REG_LAST_CODE      = 4'd15;

  localparam int ITEMS_PER_PHASE = 270;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 8;

  // One predicted response of the controller.
  typedef struct packed {
    logic [31:0] rd;
    logic        irq;
    logic        fiq;
  } response_t;

  // Mirror of the controller state and the queue of responses it still owes.
  class pending_scoreboard;
    logic [31:0] src_pnd;
    logic [31:0] mode_sel;
    logic [31:0] src_mask;
    logic [31:0] prio;
    logic [31:0] int_pnd;
    logic [4:0]  int_offset;
    logic [SubWidth-1:0] sub_pnd;
    logic [31:0] sub_msk;
    logic [31:0] ext_msk;
    logic [ExtWidth-1:0] ext_pnd;
    response_t   owed[$];
    int          op_count[8];
    int          items_noted;
    int          responses_checked;
    int          empty_scans;
    int          mismatches;

    function new();
      src_pnd    = '0;
      mode_sel   = '0;
      src_mask   = '1;
      prio       = '0;
      int_pnd    = '0;
      int_offset = '0;
      sub_pnd    = '0;
      sub_msk    = '0;
      ext_msk    = EXT_MASK_RESET;
      ext_pnd    = '0;
    endfunction

    // Apply one accepted item to the mirror and queue the response it causes.
    function void note_command(logic [2:0] op, logic [3:0] sel, logic [31:0] data,
                               logic [4:0] ln);
      response_t resp;
      logic [31:0] req;
      logic [SubWidth-1:0] sub_req;
      logic [ExtWidth-1:0] ext_req;
      bit found;
      resp = '0;
      found = 1'b0;
      items_noted++;
      op_count[op]++;
      case (op)
        CMD_READ: begin
          case (sel)
            REG_SRCPND:    resp.rd = src_pnd;
            REG_MODE:      resp.rd = mode_sel;
            REG_MASK:      resp.rd = src_mask;
            REG_PRIORITY:  resp.rd = prio;
            REG_INTPND, REG_INTOFFSET: begin
              // The scan ignores the mask; with nothing pending the offset is kept.
              if (src_pnd != '0) begin
                for (int i = 0; i < 32; i++) begin
                  if (!found && src_pnd[i]) begin
                    int_offset = 5'(i);
                    found = 1'b1;
                  end
                end
                resp.rd = (sel == REG_INTPND) ? (32'd1 << int_offset) : 32'(int_offset);
              end else begin
                empty_scans++;
              end
              int_pnd = 32'd1 << int_offset;
            end
            REG_SUBSRCPND: resp.rd = 32'(sub_pnd);
            REG_SUBMASK:   resp.rd = sub_msk;
            REG_EXTMASK:   resp.rd = ext_msk;
            REG_EXTPEND:   resp.rd = 32'(ext_pnd);
            default:       resp.rd = READ_UNMAPPED;
          endcase
        end
        CMD_WRITE: begin
          // Pending words clear the bits written as one; the offset is read-only.
          // A write to the external pending word also drops its low four lines.
          case (sel)
            REG_SRCPND:    src_pnd &= ~data;
            REG_MODE:      mode_sel = data;
            REG_MASK:      src_mask = data;
            REG_PRIORITY:  prio = data;
            REG_INTPND: begin
              int_pnd &= ~data;
              int_offset = '0;
            end
            REG_SUBSRCPND: sub_pnd &= ~data[SubWidth-1:0];
            REG_SUBMASK:   sub_msk = data;
            REG_EXTMASK:   ext_msk = data;
            REG_EXTPEND:   ext_pnd &= ~data[ExtWidth-1:0] & EXT_CLEARABLE;
            default: ;
          endcase
        end
        CMD_RAISE_EXT: begin
          if (ln < ExtWidth) begin
            ext_pnd[ln] = 1'b1;
          end
        end
        CMD_RAISE_SRC: src_pnd[ln] = 1'b1;
        CMD_RAISE_SUB: begin
          if (ln < SubWidth) begin
            sub_pnd[ln] = 1'b1;
          end
        end
        default: ;
      endcase

      // Transmit bits are always pending; unmasked feeders set their source bit.
      sub_pnd |= SUB_TX_ALWAYS;
      sub_req = sub_pnd & ~sub_msk[SubWidth-1:0];
      if (|(sub_req & SUB_GRP_UART0)) src_pnd[SRC_UART0] = 1'b1;
      if (|(sub_req & SUB_GRP_UART1)) src_pnd[SRC_UART1] = 1'b1;
      if (|(sub_req & SUB_GRP_UART2)) src_pnd[SRC_UART2] = 1'b1;
      if (|(sub_req & SUB_GRP_ADC))   src_pnd[SRC_ADC]   = 1'b1;
      ext_req = ext_pnd & ~ext_msk[ExtWidth-1:0];
      if (|(ext_req & EXT_GRP_LOW))  src_pnd[SRC_EXT_LOW]  = 1'b1;
      if (|(ext_req & EXT_GRP_HIGH)) src_pnd[SRC_EXT_HIGH] = 1'b1;

      // Request lines come from the unmasked sources after the update.
      req = src_pnd & ~src_mask;
      resp.irq = |(req & ~mode_sel);
      resp.fiq = |(req & mode_sel);
      owed.push_back(resp);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h (response %0d)", what, got, want,
               responses_checked);
      mismatches++;
    endtask

    // Compare one accepted response with the oldest prediction.
    task check_response(logic [31:0] rd, logic irq, logic fiq);
      response_t want;
      responses_checked++;
      if (owed.size() == 0) begin
        report_mismatch("response with no item outstanding", rd, '0);
        return;
      end
      want = owed.pop_front();
      if (rd !== want.rd) report_mismatch("read_data", rd, want.rd);
      if (irq !== want.irq) report_mismatch("irq_request", 32'(irq), 32'(want.irq));
      if (fiq !== want.fiq) report_mismatch("fiq_request", 32'(fiq), 32'(want.fiq));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [3:0]  reg_sel;
  logic [31:0] write_data;
  logic [4:0]  line;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_data;
  logic        irq_request;
  logic        fiq_request;

  pending_scoreboard sb;
  int send_idle_pct = 17;
  int recv_idle_pct = 56;
  int quiet_cycles  = 0;

  interrupt_controller_pending_mask uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .reg_sel     (reg_sel),
    .write_data  (write_data),
    .line        (line),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .irq_request (irq_request),
    .fiq_request (fiq_request)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, response checking and the watchdog.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_response(read_data, irq_request, fiq_request);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d responses still owed",
                 quiet_cycles, sb.owed.size());
        $display("FAIL interrupt_controller_pending_mask");
        $finish;
      end
    end
  end

  // Offer one item after an optional random gap and wait until it is taken.
  task automatic send_command(input logic [2:0] op, input logic [3:0] sel,
                              input logic [31:0] data, input logic [4:0] ln);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    reg_sel    <= sel;
    write_data <= data;
    line       <= ln;
    do @(posedge clk); while (in_stall);
    sb.note_command(op, sel, data, ln);
  endtask

  // Hold the sender off until every owed response has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_command();
    int pick;
    logic [3:0]  sel;
    logic [31:0] data;
    logic [4:0]  ln;
    pick = $urandom_range(99);
    sel = ($urandom_range(9) == 0) ? 4'($urandom_range(REG_LAST_CODE, REG_FIRST_UNMAPPED))
                                   : 4'($urandom_range(REG_EXTPEND));
    case ($urandom_range(3))
      0:       data = '0;
      1:       data = '1;
      2:       data = 32'd1 << $urandom_range(31);
      default: data = $urandom();
    endcase
    ln = 5'($urandom_range(31));
    if (pick < 30) begin
      send_command(CMD_READ, sel, data, ln);
    end else if (pick < 60) begin
      send_command(CMD_WRITE, sel, data, ln);
    end else if (pick < 72) begin
      send_command(CMD_RAISE_EXT, sel, data, ln);
    end else if (pick < 82) begin
      send_command(CMD_RAISE_SRC, sel, data, ln);
    end else if (pick < 94) begin
      // Mostly lines that exist in the sub-source word.
      if ($urandom_range(3) != 0) ln = 5'($urandom_range(SubWidth - 1));
      send_command(CMD_RAISE_SUB, sel, data, ln);
    end else if (pick < 96) begin
      send_command(3'($urandom_range(CMD_LAST_CODE, CMD_FIRST_UNKNOWN)), sel, data, ln);
    end else begin
      // Mask every feeder and clear source-pending so that the scan finds nothing.
      send_command(CMD_WRITE, REG_SUBMASK, '1, ln);
      send_command(CMD_WRITE, REG_EXTMASK, '1, ln);
      send_command(CMD_WRITE, REG_SRCPND, '1, ln);
      send_command(CMD_READ, $urandom_range(1) ? REG_INTPND : REG_INTOFFSET, data, ln);
    end
  endtask

  initial begin
    int target;
    sb = new();
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    out_stall  <= 1'b0;
    cmd        <= CMD_READ;
    reg_sel    <= REG_SRCPND;
    write_data <= '0;
    line       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: scan with nothing pending, unmapped and read-only registers, lines at the
    // ends of each word and past the external and sub-source ends, and clearing the pending words.
    send_command(CMD_READ, REG_INTPND, '0, '0);
    send_command(CMD_READ, REG_SRCPND, '0, '0);
    send_command(CMD_READ, REG_INTOFFSET, '0, '0);
    send_command(CMD_READ, REG_SUBSRCPND, '0, '0);
    send_command(CMD_READ, REG_EXTMASK, '0, '0);
    send_command(CMD_READ, REG_LAST_CODE, '0, '0);
    send_command(CMD_WRITE, REG_FIRST_UNMAPPED, '1, '0);
    send_command(CMD_WRITE, REG_INTOFFSET, '1, '0);
    send_command(CMD_WRITE, REG_MASK, '0, '0);
    send_command(CMD_WRITE, REG_PRIORITY, '1, '0);
    send_command(CMD_WRITE, REG_MODE, '1, '0);
    send_command(CMD_WRITE, REG_EXTMASK, '0, '0);
    send_command(CMD_RAISE_EXT, REG_SRCPND, '0, 5'd0);
    send_command(CMD_RAISE_EXT, REG_SRCPND, '0, 5'd23);
    send_command(CMD_RAISE_EXT, REG_SRCPND, '0, 5'd31);
    send_command(CMD_RAISE_SUB, REG_SRCPND, '0, 5'd10);
    send_command(CMD_RAISE_SUB, REG_SRCPND, '0, 5'd31);
    send_command(CMD_RAISE_SRC, REG_SRCPND, '0, 5'd0);
    send_command(CMD_RAISE_SRC, REG_SRCPND, '0, 5'd31);
    send_command(CMD_LAST_CODE, REG_LAST_CODE, '1, '1);
    send_command(CMD_WRITE, REG_SUBMASK, '1, '0);
    send_command(CMD_WRITE, REG_EXTPEND, '1, '0);
    send_command(CMD_WRITE, REG_SRCPND, '1, '0);
    send_command(CMD_WRITE, REG_INTPND, '1, '0);
    send_command(CMD_READ, REG_INTOFFSET, '0, '0);
    send_command(CMD_WRITE, REG_SUBSRCPND, '1, '0);

    // Random phases with different idle patterns; the sender drains in between.
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = sb.items_noted + ITEMS_PER_PHASE;
      while (sb.items_noted < target) send_random_command();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.owed.size() != 0) begin
      sb.report_mismatch("items left without a response", 32'(sb.owed.size()), '0);
    end
    $display("Covered %0d items: %0d reads, %0d writes, %0d line raises, %0d unknown ops.",
             sb.items_noted, sb.op_count[CMD_READ], sb.op_count[CMD_WRITE],
             sb.op_count[CMD_RAISE_EXT] + sb.op_count[CMD_RAISE_SRC]
             + sb.op_count[CMD_RAISE_SUB],
             sb.items_noted - sb.op_count[CMD_READ] - sb.op_count[CMD_WRITE]
             - sb.op_count[CMD_RAISE_EXT] - sb.op_count[CMD_RAISE_SRC]
             - sb.op_count[CMD_RAISE_SUB]);
    $display("%0d responses checked, %0d scans with nothing pending, %0d mismatches.",
             sb.responses_checked, sb.empty_scans, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS interrupt_controller_pending_mask");
    end else begin
      $display("FAIL interrupt_controller_pending_mask");
    end
    $finish;
  end

endmodule
